// File: sv/frqu_pkg.sv
`default_nettype none
package frqu_pkg;

  // rotator arctangent table, turns in q0.32
  localparam int AtanLen = 24;
  localparam logic [31:0] ATAN_TURNS [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // floor(2^32 / k) for the series divisors
  localparam logic [32:0] RECIP [1:12] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459, 33'd715827882, 33'd613566756, 33'd536870912,
    33'd477218588, 33'd429496729, 33'd390451572, 33'd357913941
  };

  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [33:0] GAIN_Q30   = 34'd652032874;
  localparam logic [24:0] LOG2E_Q24  = 25'd24204406;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [52:0] EXP_LIMIT  = 53'h16_0000_0000;

  // depolarisation pipeline depth
  localparam int DepolLat = 41;

  // configuration register indexes
  localparam logic [2:0] REG_AMP_ONE   = 3'd0;
  localparam logic [2:0] REG_AMP_TWO   = 3'd1;
  localparam logic [2:0] REG_AMP_THREE = 3'd2;
  localparam logic [2:0] REG_ROT_ONE   = 3'd3;
  localparam logic [2:0] REG_ROT_TWO   = 3'd4;
  localparam logic [2:0] REG_ROT_THREE = 3'd5;
  localparam logic [2:0] REG_PHASE     = 3'd6;
  localparam logic [2:0] REG_DEPOL     = 3'd7;

  typedef logic signed [33:0] cval_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [47:0] cfg_data_t;

endpackage
`default_nettype wire

// File: sv/frqu_phase.sv
`default_nettype none
module frqu_phase (
  input  logic               clk,
  input  logic [31:0]        lam,
  input  logic signed [31:0] rot,
  input  logic [15:0]        offset,
  output logic [31:0]        turns
);
  import frqu_pkg::*;

  logic signed [64:0] prod;
  logic signed [63:0] hic_full;
  logic [62:0]        loc_nxt;
  logic [77:0]        sum78;
  logic [63:0]        p_r;
  logic [45:0]        hic_r;
  logic [62:0]        loc_r;
  logic [31:0]        turns_r;

  // rm times lambda squared, exact
  assign prod = rot * $signed({1'b0, lam});

  // split multiply by 1/pi
  assign hic_full = $signed(p_r[63:32]) * $signed({1'b0, INV_PI_Q32});
  assign loc_nxt  = 63'(p_r[31:0]) * 63'(INV_PI_Q32);

  // recombine and keep the turn fraction
  assign sum78 = {hic_r, 32'b0} + {15'b0, loc_r};

  always_ff @(posedge clk) begin
    p_r     <= prod[63:0];
    hic_r   <= hic_full[45:0];
    loc_r   <= loc_nxt;
    turns_r <= sum78[77:46] + {offset, 16'b0};
  end

  assign turns = turns_r;

endmodule
`default_nettype wire

// File: sv/frqu_cordic.sv
`default_nettype none
module frqu_cordic #(
  parameter int STAGES = 16
) (
  input  logic            clk,
  input  logic [31:0]     phase,
  output frqu_pkg::cval_t cos_out,
  output frqu_pkg::cval_t sin_out
);
  import frqu_pkg::*;

  localparam int NE = (STAGES > AtanLen) ? AtanLen : STAGES;

  cval_t x_r [0:NE];
  cval_t y_r [0:NE];
  cval_t z_r [0:NE];
  logic  flip_r [0:NE];
  cval_t cos_r, sin_r;
  logic  flip;
  logic [31:0] ph_fold;

  // fold second and third quarter onto the right half plane
  assign flip    = phase[31] ^ phase[30];
  assign ph_fold = {phase[31] ^ flip, phase[30:0]};

  always_ff @(posedge clk) begin
    x_r[0]    <= GAIN_Q30;
    y_r[0]    <= '0;
    z_r[0]    <= {{2{ph_fold[31]}}, ph_fold};
    flip_r[0] <= flip;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NE; i++) begin : g_rot
    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      if (z_r[i][33]) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + cval_t'({2'b00, ATAN_TURNS[i]});
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - cval_t'({2'b00, ATAN_TURNS[i]});
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    cos_r <= flip_r[NE] ? -x_r[NE] : x_r[NE];
    sin_r <= flip_r[NE] ? -y_r[NE] : y_r[NE];
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule
`default_nettype wire

// File: sv/frqu_depol.sv
`default_nettype none
module frqu_depol (
  input  logic        clk,
  input  logic [31:0] lam,
  input  logic [23:0] sigma,
  output logic [30:0] depol
);
  import frqu_pkg::*;

  logic [55:0] sp_r;
  logic [36:0] t_r;
  logic        zf2_r, zf3_r;
  logic [36:0] u_r;
  logic [51:0] aa;
  logic [52:0] t_full;
  logic [61:0] u_prod;
  logic [61:0] g_prod;
  logic [25:0] a_val;

  logic [29:0] g_p  [0:12];
  logic [4:0]  n_p  [0:12];
  logic        zf_p [0:12];
  logic [30:0] r_p  [0:12];
  logic [30:0] depol_r;

  // sigma * lambda squared, then twice its square
  assign a_val  = sp_r[55:30];
  assign aa     = 52'(a_val) * 52'(a_val);
  assign t_full = {aa, 1'b0};
  assign u_prod = 62'(t_r) * 62'(LOG2E_Q24);
  assign g_prod = 62'(u_r[31:0]) * 62'(LN2_Q30);

  always_ff @(posedge clk) begin
    sp_r    <= 56'(sigma) * 56'(lam);
    t_r     <= t_full[36:0];
    zf2_r   <= (t_full >= EXP_LIMIT);
    u_r     <= u_prod[60:24];
    zf3_r   <= zf2_r;
    g_p[0]  <= g_prod[61:32];
    n_p[0]  <= u_r[36:32];
    zf_p[0] <= zf3_r;
  end

  assign r_p[0] = ONE_Q30;

  // horner series for exp(-g), three stages per term
  for (genvar j = 0; j < 12; j++) begin : g_term
    localparam int K = 12 - j;
    logic [60:0] gr;
    logic [62:0] qm;
    logic [33:0] back;
    logic [33:0] rem;
    logic [29:0] q_a_r, q_b_r, est_b_r;
    logic [29:0] g_a_r, g_b_r;
    logic [4:0]  n_a_r, n_b_r;
    logic        zf_a_r, zf_b_r;
    logic [29:0] quot;

    assign gr   = 61'(g_p[j]) * 61'(r_p[j]);
    assign qm   = 63'(q_a_r) * 63'(RECIP[K]);
    assign back = 34'(est_b_r) * 34'(K);
    assign rem  = 34'(q_b_r) - back;
    assign quot = (rem >= 34'(K)) ? est_b_r + 30'd1 : est_b_r;

    always_ff @(posedge clk) begin
      q_a_r   <= gr[59:30];
      g_a_r   <= g_p[j];
      n_a_r   <= n_p[j];
      zf_a_r  <= zf_p[j];
      q_b_r   <= q_a_r;
      est_b_r <= qm[61:32];
      g_b_r   <= g_a_r;
      n_b_r   <= n_a_r;
      zf_b_r  <= zf_a_r;
      r_p[j+1]  <= ONE_Q30 - 31'(quot);
      g_p[j+1]  <= g_b_r;
      n_p[j+1]  <= n_b_r;
      zf_p[j+1] <= zf_b_r;
    end
  end

  // base-two scale and underflow
  always_ff @(posedge clk) begin
    depol_r <= zf_p[12] ? '0 : (r_p[12] >> n_p[12]);
  end

  assign depol = depol_r;

endmodule
`default_nettype wire

// File: sv/faraday_rotation_qu_model.sv
`default_nettype none
// each cycle in which start is taken yields one result strobe, carried along the valid chain
// throughput: one sample per cycle; busy stays low, fixed-depth pipeline
// the depth is set by the exp series (twelve terms, three stages each)
// reset (synchronous, active low) clears the configuration registers and the valid chain
// the receiver cannot stall; every result is shown for exactly one cycle
module faraday_rotation_qu_model #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         in_wavelength_squared,
  output logic                out_valid,
  output logic signed [18:0]  out_stokes_q,
  output logic signed [18:0]  out_stokes_u,
  input  logic                cfg_we,
  input  frqu_pkg::cfg_idx_t  cfg_index,
  input  frqu_pkg::cfg_data_t cfg_data
);
  import frqu_pkg::*;

  localparam int NE  = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int DLY = DepolLat - (6 + NE);
  localparam int LAT = DepolLat + 2;
  localparam logic signed [25:0] SAT_HI = 26'sd196608;
  localparam logic signed [25:0] SAT_LO = -26'sd196608;

  logic [16:0] amp_r [0:2];
  logic signed [31:0] rot_r [0:2];
  logic [47:0] phase_r;
  logic [23:0] sigma_r;

  logic [LAT-1:0] vld_r;
  logic [31:0] turns [0:2];
  cval_t cs [0:2];
  cval_t sn [0:2];
  logic signed [51:0] pq_r [0:2];
  logic signed [51:0] pu_r [0:2];
  logic signed [53:0] sq_sum, su_sum;
  logic signed [31:0] sq_r [0:DLY-1];
  logic signed [31:0] su_r [0:DLY-1];
  logic [30:0] depol;
  logic signed [63:0] mq_r, mu_r;
  logic signed [25:0] vq, vu;
  logic signed [18:0] q_r, u_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r[0] <= '0; amp_r[1] <= '0; amp_r[2] <= '0;
      rot_r[0] <= '0; rot_r[1] <= '0; rot_r[2] <= '0;
      phase_r  <= '0;
      sigma_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMP_ONE:   amp_r[0] <= cfg_data[16:0];
        REG_AMP_TWO:   amp_r[1] <= cfg_data[16:0];
        REG_AMP_THREE: amp_r[2] <= cfg_data[16:0];
        REG_ROT_ONE:   rot_r[0] <= cfg_data[31:0];
        REG_ROT_TWO:   rot_r[1] <= cfg_data[31:0];
        REG_ROT_THREE: rot_r[2] <= cfg_data[31:0];
        REG_PHASE:     phase_r  <= cfg_data;
        REG_DEPOL:     sigma_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid chain follows the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // three rotation lanes
  for (genvar k = 0; k < 3; k++) begin : g_lane
    frqu_phase u_phase (
      .clk    (clk),
      .lam    (in_wavelength_squared),
      .rot    (rot_r[k]),
      .offset (phase_r[16*k +: 16]),
      .turns  (turns[k])
    );
    frqu_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk     (clk),
      .phase   (turns[k]),
      .cos_out (cs[k]),
      .sin_out (sn[k])
    );
    // weight by amplitude
    always_ff @(posedge clk) begin
      pq_r[k] <= $signed({1'b0, amp_r[k]}) * cs[k];
      pu_r[k] <= $signed({1'b0, amp_r[k]}) * sn[k];
    end
  end

  frqu_depol u_depol (
    .clk   (clk),
    .lam   (in_wavelength_squared),
    .sigma (sigma_r),
    .depol (depol)
  );

  // sum of components, aligned with the depolarisation factor
  assign sq_sum = 54'(pq_r[0]) + 54'(pq_r[1]) + 54'(pq_r[2]);
  assign su_sum = 54'(pu_r[0]) + 54'(pu_r[1]) + 54'(pu_r[2]);

  always_ff @(posedge clk) begin
    sq_r[0] <= 32'(sq_sum >>> 22);
    su_r[0] <= 32'(su_sum >>> 22);
  end

  for (genvar d = 1; d < DLY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      sq_r[d] <= sq_r[d-1];
      su_r[d] <= su_r[d-1];
    end
  end

  // scale with rounding, then saturate
  always_ff @(posedge clk) begin
    mq_r <= sq_r[DLY-1] * $signed({1'b0, depol}) + (64'sd1 <<< 37);
    mu_r <= su_r[DLY-1] * $signed({1'b0, depol}) + (64'sd1 <<< 37);
  end

  assign vq = mq_r[63:38];
  assign vu = mu_r[63:38];

  always_ff @(posedge clk) begin
    q_r <= (vq > SAT_HI) ? 19'(SAT_HI) : (vq < SAT_LO) ? 19'(SAT_LO) : 19'(vq);
    u_r <= (vu > SAT_HI) ? 19'(SAT_HI) : (vu < SAT_LO) ? 19'(SAT_LO) : 19'(vu);
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_stokes_q = q_r;
  assign out_stokes_u = u_r;

`ifndef NO_ASSERTIONS
  a_out_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching transfer");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stokes_q <= 19'sd196608) && (out_stokes_q >= -19'sd196608))
    else $error("stokes q out of range");
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stokes_u <= 19'sd196608) && (out_stokes_u >= -19'sd196608))
    else $error("stokes u out of range");
`endif

endmodule
`default_nettype wire
